### design/cqga_pkg.sv
`timescale 1ns / 1ps

package cqga_pkg;

    // one complex amplitude or coefficient, Q1.F in each part
    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
    } cplx_t;

    // request function codes
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_GATE  = 2'd2;
    localparam logic [1:0] FUNC_NOP   = 2'd3;

    // reset value of the diagonal coefficients, 1.0 in Q1.30
    localparam logic [31:0] COEF_ONE = 32'h4000_0000;

endpackage

### design/cqga_cmac.sv
`timescale 1ns / 1ps

module cqga_cmac #(
    parameter int FRAC_BITS = 30
) (
    input  logic           clk,
    input  cqga_pkg::cplx_t c0,
    input  cqga_pkg::cplx_t c1,
    input  cqga_pkg::cplx_t x,
    input  cqga_pkg::cplx_t y,
    output cqga_pkg::cplx_t res
);
    import cqga_pkg::*;

    localparam logic signed [65:0] ROUND   = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

    logic signed [63:0] prod_next [8];
    logic signed [63:0] prod_reg  [8];
    logic signed [65:0] sum_re_next, sum_im_next;
    logic signed [65:0] sum_re_reg, sum_im_reg;
    logic signed [65:0] sh_re, sh_im;

    // clamp to 32 bits; rounding to nearest comes from the half added before the shift
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX)
            r = 32'sh7fff_ffff;
        else if (v < SAT_MIN)
            r = 32'sh8000_0000;
        else
            r = 32'(v);
        return r;
    endfunction

    // eight partial products of c0*x + c1*y
    always_comb
    begin
        prod_next[0] = c0.re * x.re;
        prod_next[1] = c0.im * x.im;
        prod_next[2] = c1.re * y.re;
        prod_next[3] = c1.im * y.im;
        prod_next[4] = c0.re * x.im;
        prod_next[5] = c0.im * x.re;
        prod_next[6] = c1.re * y.im;
        prod_next[7] = c1.im * y.re;
    end

    // exact sums with the rounding half added
    always_comb
    begin
        sum_re_next = 66'(prod_reg[0]) - 66'(prod_reg[1]) + 66'(prod_reg[2])
                    - 66'(prod_reg[3]) + ROUND;
        sum_im_next = 66'(prod_reg[4]) + 66'(prod_reg[5]) + 66'(prod_reg[6])
                    + 66'(prod_reg[7]) + ROUND;
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        sum_re_reg <= sum_re_next;
        sum_im_reg <= sum_im_next;
    end

    // scale back and saturate
    always_comb
    begin
        sh_re  = sum_re_reg >>> FRAC_BITS;
        sh_im  = sum_im_reg >>> FRAC_BITS;
        res.re = sat32(sh_re);
        res.im = sat32(sh_im);
    end

endmodule

### design/controlled_qubit_gate_apply.sv
`timescale 1ns / 1ps

// Controlled single-qubit gate engine. The state vector of 2^QUBIT_COUNT complex Q1.F
// amplitudes sits in two single-port-write memory banks split by index parity, so both
// members of a pair (i, i|2^target) are read and written in the same cycle. A write
// request is stored as it is accepted; a read request goes through the read state and
// waits for a free result slot. A gate request steps through all 2^(QUBIT_COUNT-1)
// candidate pairs at one pair per cycle, the rate set by the one write port of each
// bank, then drains a four-stage read/multiply/sum/write pipeline. A target at or
// beyond QUBIT_COUNT completes at once. Memory contents are undefined until loaded;
// there is no clearing pass after reset. The user must write coefficients over the APB
// port only while the engine is idle; the block itself does not enforce this.
module controlled_qubit_gate_apply #(
    parameter int QUBIT_COUNT = 10,
    parameter int FRAC_BITS   = 30
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic [9:0]         amp_index,
    input  logic signed [31:0] write_re,
    input  logic signed [31:0] write_im,
    input  logic [3:0]         target_qubit,
    input  logic [9:0]         control_mask,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] read_re,
    output logic signed [31:0] read_im,
    output logic [9:0]         read_index,
    output logic               gate_done,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import cqga_pkg::*;

    localparam int QW         = QUBIT_COUNT;
    localparam int AW         = (QW > 1) ? QW - 1 : 1;
    localparam int BANK_DEPTH = 1 << AW;
    localparam logic [AW-1:0] LAST_PAIR = AW'((1 << (QW - 1)) - 1);

    // coefficient register indexes
    localparam logic [2:0] COEF_A_RE = 3'd0;
    localparam logic [2:0] COEF_A_IM = 3'd1;
    localparam logic [2:0] COEF_B_RE = 3'd2;
    localparam logic [2:0] COEF_B_IM = 3'd3;
    localparam logic [2:0] COEF_C_RE = 3'd4;
    localparam logic [2:0] COEF_C_IM = 3'd5;
    localparam logic [2:0] COEF_D_RE = 3'd6;
    localparam logic [2:0] COEF_D_IM = 3'd7;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_GATE  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [31:0]   coef_reg [8];
    logic [2:0]    state_reg, state_next;
    logic [QW-1:0] idx_reg, idx_next;
    logic [QW-1:0] tbit_reg, tbit_next;
    logic [QW-1:0] cm_reg, cm_next;
    logic [AW-1:0] pair_reg, pair_next;
    logic          v1_reg, v2_reg, v3_reg;
    logic [QW-1:0] i1_reg, i2_reg, i3_reg;
    logic          swap1_reg, swap2_reg, swap3_reg;
    logic          out_valid_reg, out_valid_next;
    logic          load_read, load_gate;
    cplx_t         out_amp_reg;
    logic [9:0]    out_index_reg;
    logic          out_done_reg;

    logic          accept, slot_free, tgt_ok;
    logic [QW-1:0] in_idx, kk, low_mask, pair_i, pair_j, j3;
    logic          active, issue, par_i;
    logic [AW-1:0] ra0, ra1, wa0, wa1;
    logic          we0, we1, wr_item;
    cplx_t         wd0, wd1, rd0_reg, rd1_reg;
    cplx_t         bank0_mem [BANK_DEPTH];
    cplx_t         bank1_mem [BANK_DEPTH];
    cplx_t         x_amp, y_amp, res_i, res_j, read_amp;
    cplx_t         coef_a, coef_b, coef_c, coef_d;

    // handshake
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign wr_item   = accept && (func == FUNC_WRITE);
    assign in_idx    = QW'({20'b0, amp_index});
    assign tgt_ok    = {1'b0, target_qubit} < 5'(QUBIT_COUNT);

    // config port
    assign pready = 1'b1;
    assign prdata = coef_reg[paddr[4:2]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // identity matrix: ones on the diagonal real parts
            for (int k = 0; k < 8; k++)
                coef_reg[k] <= (3'(k) == COEF_A_RE || 3'(k) == COEF_D_RE) ? COEF_ONE : '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            coef_reg[paddr[4:2]] <= pwdata;
        end
    end

    assign coef_a = cplx_t'({coef_reg[COEF_A_RE], coef_reg[COEF_A_IM]});
    assign coef_b = cplx_t'({coef_reg[COEF_B_RE], coef_reg[COEF_B_IM]});
    assign coef_c = cplx_t'({coef_reg[COEF_C_RE], coef_reg[COEF_C_IM]});
    assign coef_d = cplx_t'({coef_reg[COEF_D_RE], coef_reg[COEF_D_IM]});

    // pair index: insert a zero at the target bit of the pair count
    always_comb
    begin
        kk       = QW'({1'b0, pair_reg});
        low_mask = tbit_reg - QW'(1);
        pair_i   = ((kk & ~low_mask) << 1) | (kk & low_mask);
        pair_j   = pair_i | tbit_reg;
        par_i    = ^pair_i;
        active   = (pair_i & cm_reg) == cm_reg;
        issue    = (state_reg == ST_GATE) && active;
    end

    // read addresses per bank
    always_comb
    begin
        case (state_reg)
            ST_GATE:
            begin
                ra0 = AW'((par_i ? pair_j : pair_i) >> 1);
                ra1 = AW'((par_i ? pair_i : pair_j) >> 1);
            end
            ST_READ:
            begin
                ra0 = AW'(idx_reg >> 1);
                ra1 = AW'(idx_reg >> 1);
            end
            default:
            begin
                ra0 = AW'(in_idx >> 1);
                ra1 = AW'(in_idx >> 1);
            end
        endcase
    end

    // write-back of a finished pair, or a loaded amplitude
    always_comb
    begin
        j3 = i3_reg | tbit_reg;
        if (v3_reg)
        begin
            we0 = 1'b1;
            we1 = 1'b1;
            wa0 = AW'((swap3_reg ? j3 : i3_reg) >> 1);
            wa1 = AW'((swap3_reg ? i3_reg : j3) >> 1);
            wd0 = swap3_reg ? res_j : res_i;
            wd1 = swap3_reg ? res_i : res_j;
        end
        else
        begin
            we0 = wr_item && !(^in_idx);
            we1 = wr_item && (^in_idx);
            wa0 = AW'(in_idx >> 1);
            wa1 = AW'(in_idx >> 1);
            wd0 = cplx_t'({write_re, write_im});
            wd1 = cplx_t'({write_re, write_im});
        end
    end

    // amplitude banks, even and odd index parity
    always_ff @(posedge clk)
    begin
        if (we0)
            bank0_mem[wa0] <= wd0;
        rd0_reg <= bank0_mem[ra0];
    end

    always_ff @(posedge clk)
    begin
        if (we1)
            bank1_mem[wa1] <= wd1;
        rd1_reg <= bank1_mem[ra1];
    end

    assign x_amp    = swap1_reg ? rd1_reg : rd0_reg;
    assign y_amp    = swap1_reg ? rd0_reg : rd1_reg;
    assign read_amp = (^idx_reg) ? rd1_reg : rd0_reg;

    // new amplitude at i from row 0, at j from row 1
    cqga_cmac #(.FRAC_BITS(FRAC_BITS)) u_row0 (
        .clk (clk),
        .c0  (coef_a),
        .c1  (coef_b),
        .x   (x_amp),
        .y   (y_amp),
        .res (res_i)
    );

    cqga_cmac #(.FRAC_BITS(FRAC_BITS)) u_row1 (
        .clk (clk),
        .c0  (coef_c),
        .c1  (coef_d),
        .x   (x_amp),
        .y   (y_amp),
        .res (res_j)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        tbit_next      = tbit_reg;
        cm_next        = cm_reg;
        pair_next      = pair_reg;
        load_read      = 1'b0;
        load_gate      = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        FUNC_READ:
                        begin
                            idx_next   = in_idx;
                            state_next = ST_READ;
                        end
                        FUNC_GATE:
                        begin
                            tbit_next  = QW'(1) << target_qubit;
                            cm_next    = QW'({20'b0, control_mask}) & ~tbit_next;
                            pair_next  = '0;
                            state_next = tgt_ok ? ST_GATE : ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (slot_free)
                begin
                    load_read      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_GATE:
            begin
                pair_next = pair_reg + AW'(1);
                if (pair_reg == LAST_PAIR)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg && !v3_reg)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    load_gate      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            v1_reg        <= issue;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        tbit_reg  <= tbit_next;
        cm_reg    <= cm_next;
        pair_reg  <= pair_next;
        i1_reg    <= pair_i;
        i2_reg    <= i1_reg;
        i3_reg    <= i2_reg;
        swap1_reg <= par_i;
        swap2_reg <= swap1_reg;
        swap3_reg <= swap2_reg;
        if (load_read)
        begin
            out_amp_reg   <= read_amp;
            out_index_reg <= 10'({20'b0, idx_reg});
            out_done_reg  <= 1'b0;
        end
        else if (load_gate)
        begin
            out_amp_reg   <= '0;
            out_index_reg <= '0;
            out_done_reg  <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_re    = out_amp_reg.re;
    assign read_im    = out_amp_reg.im;
    assign read_index = out_index_reg;
    assign gate_done  = out_done_reg;

    // gate pipeline is empty whenever new requests are taken
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!v1_reg && !v2_reg && !v3_reg))
        else $error("gate pipeline busy while idle");

    // a result only comes from a read or a finished gate
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_READ || $past(state_reg) == ST_DONE))
        else $error("result without read or gate");

    // loaded amplitudes never collide with gate write-back
    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> !wr_item)
        else $error("amplitude write during gate write-back");

endmodule
